// File: sv/ipcso_pkg.sv
// Shared types and constants for the IPv4 TCP/UDP checksum offload core.
`timescale 1ns / 1ps
`default_nettype none

package ipcso_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_IPV4  = 3'd1,
        ST_NOT_L4    = 3'd2,
        ST_SHORT     = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    localparam int unsigned IDX_MAX = 4095;

    localparam logic [11:0] POS_VER_IHL = 12'd14;
    localparam logic [11:0] POS_LEN_HI  = 12'd16;
    localparam logic [11:0] POS_LEN_LO  = 12'd17;
    localparam logic [11:0] POS_PROTO   = 12'd23;
    localparam logic [11:0] POS_ADDR_LO = 12'd26;
    localparam logic [11:0] POS_ADDR_HI = 12'd33;
    localparam logic [11:0] POS_L4_MIN  = 12'd34;

    localparam logic [6:0]  ETH_HDR      = 7'd14;
    localparam logic [7:0]  L4_TCP       = 8'd6;
    localparam logic [7:0]  L4_UDP       = 8'd17;
    localparam logic [4:0]  TCP_CSUM_OFF = 5'd16;
    localparam logic [4:0]  UDP_CSUM_OFF = 5'd6;

    localparam logic [7:0]  VER_MASK = 8'hf0;
    localparam logic [7:0]  VER_IPV4 = 8'h40;
    localparam logic [7:0]  IHL_MASK = 8'h0f;
    localparam logic [3:0]  IHL_MIN  = 4'd5;

endpackage

`default_nettype wire

// File: sv/ipv4_l4_checksum_offload_core.sv
// Streaming TCP/UDP checksum calculator for IPv4 in Ethernet frames.
//
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_ready, frame_byte, last_byte | sink
//  out     | out_valid, out_ready, status, checksum,   | source
//          | checksum_position                       |
//
// One frame byte per cycle while in_ready is high; the running sum takes at most one add per byte.
// A result passes through a 3-register pipe: input, finish and output stages.
// rst_n clears all frame state and empties the pipe.
// in_ready drops only when a last byte waits behind two undelivered results.
// Bytes past min(MAX_FRAME_BYTES, 4095) are taken and ignored.
`timescale 1ns / 1ps
`default_nettype none

module ipv4_l4_checksum_offload_core #(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  frame_byte,
    input  wire logic        last_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [15:0]      checksum,
    output logic [6:0]       checksum_position
);

    localparam int unsigned CAPACITY = (MAX_FRAME_BYTES < ipcso_pkg::IDX_MAX) ?
                                       MAX_FRAME_BYTES : ipcso_pkg::IDX_MAX;
    localparam logic [11:0] CAP_W = 12'(CAPACITY);

    function automatic logic [4:0] csum_off(input logic [7:0] proto);
        logic [4:0] off;
        off = 5'd0;
        if (proto == ipcso_pkg::L4_TCP)
            off = ipcso_pkg::TCP_CSUM_OFF;
        else if (proto == ipcso_pkg::L4_UDP)
            off = ipcso_pkg::UDP_CSUM_OFF;
        return off;
    endfunction

    // input stage
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    // frame state
    logic [11:0] byte_index_reg;
    logic        ver_ok_reg;
    logic [5:0]  hdr_bytes_reg;
    logic [15:0] total_len_reg;
    logic [7:0]  proto_reg;
    logic [27:0] run_sum_reg;

    // finish stage
    logic                 s2_valid_reg;
    ipcso_pkg::status_t   s2_status_reg;
    logic [27:0]          s2_sum_reg;
    logic [7:0]           s2_proto_reg;
    logic [15:0]          s2_plen_reg;
    logic [6:0]           s2_cpos_reg;

    // output stage
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [15:0] checksum_reg;
    logic [6:0]  cpos_reg;

    logic s2_adv, s2_free, s1_adv, s1_fire, in_fire;

    assign s2_adv   = !out_valid_reg || out_ready;
    assign s2_free  = !s2_valid_reg || s2_adv;
    assign s1_adv   = !s1_last_reg || s2_free;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // per-byte update
    logic        take;
    logic [11:0] pos;
    logic        ver_next;
    logic [5:0]  hb_next;
    logic [15:0] tl_next;
    logic [7:0]  proto_next;
    logic [11:0] cnt_next;
    logic [27:0] sum_next;
    logic [27:0] add_val;
    logic [6:0]  l4_start;
    logic [16:0] l4_end;
    logic [4:0]  off_next;
    logic [6:0]  cpos_next;
    logic        in_addr, in_l4, skip, do_add;

    assign take = byte_index_reg < CAP_W;
    assign pos  = byte_index_reg;

    always_comb
    begin
        ver_next   = ver_ok_reg;
        hb_next    = hdr_bytes_reg;
        tl_next    = total_len_reg;
        proto_next = proto_reg;
        if (take)
        begin
            unique case (pos)
                ipcso_pkg::POS_VER_IHL:
                begin
                    ver_next = ((s1_byte_reg & ipcso_pkg::VER_MASK) == ipcso_pkg::VER_IPV4) &&
                               (s1_byte_reg[3:0] >= ipcso_pkg::IHL_MIN);
                    hb_next  = {s1_byte_reg[3:0], 2'b00};
                end
                ipcso_pkg::POS_LEN_HI: tl_next    = {s1_byte_reg, total_len_reg[7:0]};
                ipcso_pkg::POS_LEN_LO: tl_next    = {total_len_reg[15:8], s1_byte_reg};
                ipcso_pkg::POS_PROTO:  proto_next = s1_byte_reg;
                default: ;
            endcase
        end
    end

    assign add_val   = pos[0] ? {20'd0, s1_byte_reg} : {12'd0, s1_byte_reg, 8'd0};
    assign l4_start  = ipcso_pkg::ETH_HDR + {1'b0, hb_next};
    assign l4_end    = {10'd0, ipcso_pkg::ETH_HDR} + {1'b0, tl_next};
    assign off_next  = csum_off(proto_next);
    assign cpos_next = l4_start + {2'b00, off_next};

    assign in_addr = (pos >= ipcso_pkg::POS_ADDR_LO) && (pos <= ipcso_pkg::POS_ADDR_HI);
    assign in_l4   = ver_next && (pos >= ipcso_pkg::POS_L4_MIN) &&
                     (pos >= {5'd0, l4_start}) && ({5'd0, pos} < l4_end);
    assign skip    = (off_next != 5'd0) &&
                     ((pos == {5'd0, cpos_next}) || (pos == ({5'd0, cpos_next} + 12'd1)));
    assign do_add  = take && (in_addr || (in_l4 && !skip));
    assign sum_next = do_add ? run_sum_reg + add_val : run_sum_reg;
    assign cnt_next = take ? byte_index_reg + 12'd1 : byte_index_reg;

    // end-of-frame checks
    logic [15:0]        plen_next;
    ipcso_pkg::status_t fin_status;

    assign plen_next = tl_next - {10'd0, hb_next};

    always_comb
    begin
        priority if (cnt_next <= {5'd0, ipcso_pkg::ETH_HDR})
            fin_status = ipcso_pkg::ST_TRUNC;
        else if (!ver_next)
            fin_status = ipcso_pkg::ST_NOT_IPV4;
        else if (cnt_next <= ipcso_pkg::POS_PROTO)
            fin_status = ipcso_pkg::ST_TRUNC;
        else if (off_next == 5'd0)
            fin_status = ipcso_pkg::ST_NOT_L4;
        else if ((tl_next < {10'd0, hb_next}) ||
                 (plen_next < ({11'd0, off_next} + 16'd2)))
            fin_status = ipcso_pkg::ST_SHORT;
        else if ({5'd0, cnt_next} < l4_end)
            fin_status = ipcso_pkg::ST_TRUNC;
        else
            fin_status = ipcso_pkg::ST_OK;
    end

    // fold and complement
    logic [27:0] tot_sum;
    logic [16:0] fold1;
    logic [16:0] fold2;
    logic [15:0] csum_raw;
    logic [15:0] csum_fin;

    assign tot_sum  = s2_sum_reg + {20'd0, s2_proto_reg} + {12'd0, s2_plen_reg};
    assign fold1    = {1'b0, tot_sum[15:0]} + {5'd0, tot_sum[27:16]};
    assign fold2    = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
    assign csum_raw = ~fold2[15:0];
    assign csum_fin = (s2_status_reg != ipcso_pkg::ST_OK) ? 16'd0 :
                      ((s2_proto_reg == ipcso_pkg::L4_UDP) && (csum_raw == 16'd0)) ?
                      16'hffff : csum_raw;

    logic s1_valid_next, s2_valid_next, out_valid_next;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_adv);
    assign s2_valid_next  = (s1_fire && s1_last_reg) || (s2_valid_reg && !s2_adv);
    assign out_valid_next = (s2_valid_reg && s2_adv) || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            byte_index_reg <= 12'd0;
            ver_ok_reg     <= 1'b0;
            hdr_bytes_reg  <= 6'd0;
            total_len_reg  <= 16'd0;
            proto_reg      <= 8'd0;
            run_sum_reg    <= 28'd0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_fire)
            begin
                if (s1_last_reg)
                begin
                    byte_index_reg <= 12'd0;
                    ver_ok_reg     <= 1'b0;
                    hdr_bytes_reg  <= 6'd0;
                    total_len_reg  <= 16'd0;
                    proto_reg      <= 8'd0;
                    run_sum_reg    <= 28'd0;
                end
                else
                begin
                    byte_index_reg <= cnt_next;
                    ver_ok_reg     <= ver_next;
                    hdr_bytes_reg  <= hb_next;
                    total_len_reg  <= tl_next;
                    proto_reg      <= proto_next;
                    run_sum_reg    <= sum_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= frame_byte;
            s1_last_reg <= last_byte;
        end
        if (s1_fire && s1_last_reg)
        begin
            s2_status_reg <= fin_status;
            s2_sum_reg    <= sum_next;
            s2_proto_reg  <= proto_next;
            s2_plen_reg   <= plen_next;
            s2_cpos_reg   <= (fin_status == ipcso_pkg::ST_OK) ? cpos_next : 7'd0;
        end
        if (s2_valid_reg && s2_adv)
        begin
            status_reg   <= s2_status_reg;
            checksum_reg <= csum_fin;
            cpos_reg     <= s2_cpos_reg;
        end
    end

    assign out_valid         = out_valid_reg;
    assign status            = status_reg;
    assign checksum          = checksum_reg;
    assign checksum_position = cpos_reg;

endmodule

`default_nettype wire

// File: sv/ipcso_checker.sv
// Port-level assertions for the checksum offload core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ipcso_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [15:0] checksum,
    input wire logic [6:0]  checksum_position
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(checksum) && $stable(checksum_position))
        else $error("result beat changed while stalled");

    // input stalls only behind a stalled result beat
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with the result side free");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ipcso_pkg::ST_TRUNC)
        else $error("status code out of range");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ipcso_pkg::ST_OK |-> checksum == 16'd0 &&
        checksum_position == 7'd0)
        else $error("checksum fields set on error status");

    // minimum header is 20 bytes, smallest offset is UDP
    a_pos_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ipcso_pkg::ST_OK |-> checksum_position >= 7'd40 &&
        checksum_position <= 7'd93)
        else $error("checksum position outside the L4 header range");

endmodule

bind ipv4_l4_checksum_offload_core ipcso_checker u_ipcso_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .checksum          (checksum),
    .checksum_position (checksum_position)
);

`default_nettype wire

// File: bench/ipv4_l4_checksum_offload_core_tb.sv
// Testbench for the IPv4 TCP/UDP checksum offload core: frame stimulus and checksum scoreboard.
`timescale 1ns / 1ps

module ipv4_l4_checksum_offload_core_tb;

    localparam int unsigned MAX_FRAME_BYTES = 2048;
    localparam int unsigned FRAME_CAP = (MAX_FRAME_BYTES < ipcso_pkg::IDX_MAX) ?
                                        MAX_FRAME_BYTES : ipcso_pkg::IDX_MAX;
    localparam int unsigned HOLD_CYCLES = 600;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned TOTAL_BEATS = 1300;

    typedef enum int unsigned {RX_STEADY, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

    class l4_csum_scoreboard;
        typedef struct packed {
            ipcso_pkg::status_t st;
            logic [15:0]        sum;
            logic [6:0]         pos;
        } csum_result_t;

        logic [11:0]  nbytes = '0;
        logic         ver_ok = 1'b0;
        logic [5:0]   hdr_len = '0;
        logic [15:0]  ip_len = '0;
        logic [7:0]   proto = '0;
        logic [31:0]  acc = '0;
        csum_result_t expected_results[$];
        int unsigned  errors = 0;

        function void clear_frame();
            nbytes = '0;
            ver_ok = 1'b0;
            hdr_len = '0;
            ip_len = '0;
            proto = '0;
            acc = '0;
        endfunction

        function int unsigned slot_offset(logic [7:0] p);
            if (p == ipcso_pkg::L4_TCP)
                return 32'(ipcso_pkg::TCP_CSUM_OFF);
            if (p == ipcso_pkg::L4_UDP)
                return 32'(ipcso_pkg::UDP_CSUM_OFF);
            return 0;
        endfunction

        function void accumulate_byte(logic [11:0] p, logic [7:0] b);
            logic [31:0] term;
            int unsigned pi, l4_lo, l4_hi, cs_at, off;
            pi = 32'(p);
            term = p[0] ? {24'd0, b} : {16'd0, b, 8'd0};
            if (p == ipcso_pkg::POS_VER_IHL)
            begin
                ver_ok = ((b & ipcso_pkg::VER_MASK) == ipcso_pkg::VER_IPV4) &&
                         ((b & ipcso_pkg::IHL_MASK) >= 8'(ipcso_pkg::IHL_MIN));
                hdr_len = {b[3:0], 2'b00};
            end
            else if (p == ipcso_pkg::POS_LEN_HI)
                ip_len[15:8] = b;
            else if (p == ipcso_pkg::POS_LEN_LO)
                ip_len[7:0] = b;
            else if (p == ipcso_pkg::POS_PROTO)
                proto = b;

            if (p >= ipcso_pkg::POS_ADDR_LO && p <= ipcso_pkg::POS_ADDR_HI)
                acc += term;
            else if (ver_ok)
            begin
                l4_lo = 32'(ipcso_pkg::ETH_HDR) + 32'(hdr_len);
                l4_hi = 32'(ipcso_pkg::ETH_HDR) + 32'(ip_len);
                off = slot_offset(proto);
                cs_at = l4_lo + off;
                if (p >= ipcso_pkg::POS_L4_MIN && pi >= l4_lo && pi < l4_hi &&
                    !(off != 0 && (pi == cs_at || pi == cs_at + 1)))
                    acc += term;
            end
        endfunction

        function csum_result_t frame_verdict();
            csum_result_t r;
            int unsigned off, cnt, len, hl, at;
            logic [31:0] s;
            r.st = ipcso_pkg::ST_OK;
            r.sum = '0;
            r.pos = '0;
            off = slot_offset(proto);
            cnt = 32'(nbytes);
            len = 32'(ip_len);
            hl = 32'(hdr_len);
            if (cnt <= 32'(ipcso_pkg::ETH_HDR))
                r.st = ipcso_pkg::ST_TRUNC;
            else if (!ver_ok)
                r.st = ipcso_pkg::ST_NOT_IPV4;
            else if (cnt <= 32'(ipcso_pkg::POS_PROTO))
                r.st = ipcso_pkg::ST_TRUNC;
            else if (off == 0)
                r.st = ipcso_pkg::ST_NOT_L4;
            else if (len < hl || len - hl < off + 2)
                r.st = ipcso_pkg::ST_SHORT;
            else if (cnt < 32'(ipcso_pkg::ETH_HDR) + len)
                r.st = ipcso_pkg::ST_TRUNC;
            else
            begin
                s = acc + 32'(proto) + (len - hl);
                while (s[31:16] != 0)
                    s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
                r.sum = ~s[15:0];
                if (proto == ipcso_pkg::L4_UDP && r.sum == 16'h0000)
                    r.sum = 16'hFFFF;
                at = 32'(ipcso_pkg::ETH_HDR) + hl + off;
                r.pos = at[6:0];
            end
            return r;
        endfunction

        function void note_beat(logic [7:0] b, logic lst);
            if (nbytes < 12'(FRAME_CAP))
            begin
                accumulate_byte(nbytes, b);
                nbytes++;
            end
            if (lst)
            begin
                expected_results.push_back(frame_verdict());
                clear_frame();
            end
        endfunction

        function void check_result(logic [2:0] st, logic [15:0] sum, logic [6:0] pos);
            csum_result_t w;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d checksum %h", st, sum);
                errors++;
                return;
            end
            w = expected_results.pop_front();
            if (st !== w.st)
            begin
                $error("status: expected %0d, actual %0d", w.st, st);
                errors++;
            end
            if (sum !== w.sum)
            begin
                $error("checksum: expected %h, actual %h", w.sum, sum);
                errors++;
            end
            if (pos !== w.pos)
            begin
                $error("checksum_position: expected %0d, actual %0d", w.pos, pos);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [15:0] checksum;
    logic [6:0]  checksum_position;

    l4_csum_scoreboard csum_check;
    logic [7:0]  frame_q[$];
    int unsigned burst_left;
    int unsigned beats_sent;
    int unsigned results_seen;
    int unsigned quiet;

    ipv4_l4_checksum_offload_core #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .frame_byte(frame_byte),
        .last_byte(last_byte),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .checksum(checksum),
        .checksum_position(checksum_position)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function void build_frame(logic [7:0] ver_ihl, logic [7:0] l4_proto,
                              int unsigned tot_len, int unsigned flen, bit noisy);
        frame_q.delete();
        for (int unsigned i = 0; i < flen; i++)
            frame_q.push_back(noisy ? 8'($urandom) : 8'h00);
        if (flen > 32'(ipcso_pkg::POS_VER_IHL))
            frame_q[ipcso_pkg::POS_VER_IHL] = ver_ihl;
        if (flen > 32'(ipcso_pkg::POS_LEN_HI))
            frame_q[ipcso_pkg::POS_LEN_HI] = 8'(tot_len >> 8);
        if (flen > 32'(ipcso_pkg::POS_LEN_LO))
            frame_q[ipcso_pkg::POS_LEN_LO] = 8'(tot_len);
        if (flen > 32'(ipcso_pkg::POS_PROTO))
            frame_q[ipcso_pkg::POS_PROTO] = l4_proto;
    endfunction

    // called and returns at a falling edge
    task automatic send_beat(input logic [7:0] b, input logic lst);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                frame_byte <= 8'($urandom);
                last_byte <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        in_valid <= 1'b1;
        frame_byte <= b;
        last_byte <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        csum_check.note_beat(b, lst);
        beats_sent++;
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_frame();
        for (int unsigned i = 0; i < frame_q.size(); i++)
            send_beat(frame_q[i], i == frame_q.size() - 1);
    endtask

    task automatic send_ipv4(input logic [7:0] ver_ihl, input logic [7:0] l4_proto,
                             input int unsigned tot_len, input int unsigned flen);
        build_frame(ver_ihl, l4_proto, tot_len, flen, 1'b1);
        send_frame();
    endtask

    task automatic random_frame();
        int unsigned kind, hl, l4, tot, pad;
        logic [7:0] vi, pr;
        kind = $urandom_range(0, 99);
        hl = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
        pr = ($urandom_range(0, 1) == 0) ? ipcso_pkg::L4_TCP : ipcso_pkg::L4_UDP;
        l4 = (pr == ipcso_pkg::L4_TCP) ? $urandom_range(18, 60) : $urandom_range(8, 50);
        vi = {4'h4, 4'(hl)};
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
        tot = hl * 4 + l4;
        if (kind < 65)
            build_frame(vi, pr, tot, 14 + tot + pad, 1'b1);
        else if (kind < 73)
            build_frame(vi, pr, tot, $urandom_range(1, 13 + tot), 1'b1);
        else if (kind < 79)
        begin
            vi[7:4] = 4'($urandom_range(0, 15));
            if (vi[7:4] == 4'h4)
                vi[3:0] = 4'($urandom_range(0, 4));
            build_frame(vi, pr, tot, 14 + tot + pad, 1'b1);
        end
        else if (kind < 85)
        begin
            pr = 8'($urandom);
            if (pr == ipcso_pkg::L4_TCP || pr == ipcso_pkg::L4_UDP)
                pr = 8'd1;
            build_frame(vi, pr, tot, 14 + tot + pad, 1'b1);
        end
        else if (kind < 91)
        begin
            if ($urandom_range(0, 1) == 0)
                tot = $urandom_range(0, hl * 4 - 1);
            else
                tot = hl * 4 + $urandom_range(0, (pr == ipcso_pkg::L4_TCP) ? 17 : 7);
            build_frame(vi, pr, tot, 14 + hl * 4 + $urandom_range(0, 24), 1'b1);
        end
        else
            build_frame(8'($urandom), 8'($urandom), $urandom_range(0, 65535),
                        $urandom_range(1, 80), 1'b1);
    endtask

    task automatic directed_frames();
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 40, 1);
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 40, 14);
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 40, 20);
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 40, 24);
        send_ipv4(8'h65, ipcso_pkg::L4_TCP, 40, 54);
        send_ipv4(8'h44, ipcso_pkg::L4_UDP, 28, 42);
        send_ipv4(8'h00, 8'h00, 0, 60);
        send_ipv4(8'hFF, 8'hFF, 65535, 60);
        send_ipv4(8'h45, 8'd1, 40, 54);
        send_ipv4(8'h45, 8'hFF, 40, 54);
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 10, 60);
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 37, 60);
        send_ipv4(8'h45, ipcso_pkg::L4_TCP, 38, 52);
        send_ipv4(8'h45, ipcso_pkg::L4_UDP, 27, 60);
        send_ipv4(8'h45, ipcso_pkg::L4_UDP, 28, 42);
        send_ipv4(8'h4F, ipcso_pkg::L4_TCP, 100, 119);
        send_ipv4(8'h46, ipcso_pkg::L4_UDP, 65535, 80);
        // UDP sum folds to all ones: zero checksum goes out as FFFF
        build_frame(8'h45, ipcso_pkg::L4_UDP, 30, 44, 1'b0);
        frame_q[42] = 8'hFF;
        frame_q[43] = 8'hE4;
        send_frame();
        // same for TCP: zero stays zero
        build_frame(8'h45, ipcso_pkg::L4_TCP, 42, 56, 1'b0);
        frame_q[54] = 8'hFF;
        frame_q[55] = 8'hE3;
        send_frame();
    endtask

    initial
    begin
        csum_check = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        frame_byte = 8'h00;
        last_byte = 1'b0;
        burst_left = 0;
        beats_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        directed_frames();
        while (beats_sent < TOTAL_BEATS)
        begin
            random_frame();
            send_frame();
        end
        in_valid <= 1'b0;
        last_byte <= 1'b0;
        while (csum_check.expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (csum_check.errors == 0 && csum_check.expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // result side: one long hold-off early on, then changing stall patterns
    initial
    begin
        rx_mode_t mode;
        int unsigned tick, hold;
        bit held_off;
        out_ready = 1'b0;
        mode = RX_STEADY;
        tick = 0;
        held_off = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && results_seen >= 2)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++)
                    @(negedge clk);
            end
            if (tick % 64 == 0)
                mode = rx_mode_t'($urandom_range(0, 3));
            tick++;
            case (mode)
                RX_STEADY: out_ready <= 1'b1;
                RX_HALF:   out_ready <= ($urandom_range(0, 1) == 1);
                RX_SPARSE: out_ready <= (tick % 4 == 0);
                default:   out_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
        results_seen = 0;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            csum_check.check_result(status, checksum, checksum_position);
            results_seen++;
        end
    end

    initial
        quiet = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

endmodule
